// ===== hw/rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the serial frame receiver
// frame layout positions, register map and reset values
// ----------------------------------------------------------------------------
package sfr_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] pos_type;

   // frame layout: header, five payload bytes, checksum, footer
   localparam int unsigned PayloadBytes = 5;
   localparam pos_type FirstPayloadPos = 3'd1;
   localparam pos_type LastPayloadPos  = 3'd5;
   localparam pos_type SumPos          = 3'd6;
   localparam pos_type FooterPos       = 3'd7;

   // register map, indexed by the word address
   typedef enum logic {
      CSR_HEADER = 1'b0,
      CSR_FOOTER = 1'b1
   } csr_index_type;

   localparam byte_type HeaderReset = 8'hAA;
   localparam byte_type FooterReset = 8'h55;

   // status codes of a finished frame
   localparam logic StatusOk  = 1'b0;
   localparam logic StatusErr = 1'b1;

endpackage

// ===== hw/rtl/serial_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver_top: fixed length header/footer frame receiver
// hunts for a header byte, gathers an eight byte frame, checks sum and footer
// ----------------------------------------------------------------------------
// One received byte enters per request on the req_ channel and the block takes
// a new byte every clock cycle unless a result sits stalled at the output. Each
// byte first lands in an input register; when it moves on, the frame position
// counter, the running 8-bit sum and the payload registers are updated from it,
// and when the footer byte is reached a result with the five payload bytes and
// a status (0 ok, 1 footer or checksum mismatch) is loaded into the output
// register. Bytes that do not finish a frame give no result. A result waiting
// under rsp_stall holds only the input register; the byte in it moves on as
// soon as the output register is free or being emptied. While hunting, only a
// byte equal to header_byte opens a frame; inside a frame every byte is data,
// and a bad frame is still consumed whole before hunting resumes. header_byte
// (address 0) and footer_byte (address 4) are written through the APB-style
// csr_ port, by the user only while no frame is in flight; nothing enforces it.
// ----------------------------------------------------------------------------
module serial_frame_receiver_top (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_command,
   output logic [7:0]       rsp_board,
   output logic [7:0]       rsp_channel_number,
   output logic [7:0]       rsp_first_param,
   output logic [7:0]       rsp_second_param,
   output logic             rsp_status,
   // configuration port
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // configuration registers
   sfr_pkg::byte_type header_ff, header_in;
   sfr_pkg::byte_type footer_ff, footer_in;
   sfr_pkg::csr_index_type csr_index;
   logic csr_write;

   // input register
   logic              in_valid_ff, in_valid_in;
   sfr_pkg::byte_type in_byte_ff, in_byte_in;

   // frame state
   logic              in_frame_ff, in_frame_in;
   sfr_pkg::pos_type  pos_ff, pos_in;
   sfr_pkg::byte_type sum_ff, sum_in;
   sfr_pkg::byte_type rx_sum_ff, rx_sum_in;
   sfr_pkg::byte_type payload_ff [sfr_pkg::PayloadBytes];
   logic              payload_we;
   sfr_pkg::pos_type  payload_idx;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic              out_load;
   logic              out_status_in;
   sfr_pkg::byte_type out_payload_ff [sfr_pkg::PayloadBytes];
   logic              out_status_ff;

   logic advance;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_index  = sfr_pkg::csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      header_in = header_ff;
      footer_in = footer_ff;
      if (csr_write) begin
         case (csr_index)
            sfr_pkg::CSR_HEADER: header_in = csr_pwdata[7:0];
            sfr_pkg::CSR_FOOTER: footer_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         sfr_pkg::CSR_HEADER: csr_prdata = {24'd0, header_ff};
         sfr_pkg::CSR_FOOTER: csr_prdata = {24'd0, footer_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   // the input byte moves on unless a finished result sits stalled at the output
   assign advance     = in_valid_ff & ~(out_valid_ff & rsp_stall);
   assign req_stall   = in_valid_ff & ~advance;
   assign in_valid_in = req_valid | (in_valid_ff & ~advance);
   assign in_byte_in  = (req_valid & ~req_stall) ? req_rx_byte : in_byte_ff;

   // ---------------------------------------------------------------- frame logic
   always_comb begin
      in_frame_in   = in_frame_ff;
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      rx_sum_in     = rx_sum_ff;
      payload_we    = 1'b0;
      payload_idx   = pos_ff - 3'd1;
      out_load      = 1'b0;
      out_status_in = sfr_pkg::StatusOk;
      if (advance) begin
         if (!in_frame_ff) begin
            // hunting: only the header value opens a frame
            if (in_byte_ff == header_ff) begin
               in_frame_in = 1'b1;
               pos_in      = sfr_pkg::FirstPayloadPos;
               sum_in      = in_byte_ff;
            end
         end else if (pos_ff inside {[sfr_pkg::FirstPayloadPos:sfr_pkg::LastPayloadPos]}) begin
            payload_we = 1'b1;
            sum_in     = sum_ff + in_byte_ff;
            pos_in     = pos_ff + 3'd1;
         end else if (pos_ff == sfr_pkg::SumPos) begin
            rx_sum_in = in_byte_ff;
            pos_in    = sfr_pkg::FooterPos;
         end else begin
            // footer byte closes the frame and always yields a result
            out_load      = 1'b1;
            out_status_in = (in_byte_ff == footer_ff && rx_sum_ff == sum_ff)
                            ? sfr_pkg::StatusOk : sfr_pkg::StatusErr;
            in_frame_in   = 1'b0;
            pos_in        = '0;
            sum_in        = '0;
         end
      end
   end

   assign out_valid_in = out_load | (out_valid_ff & rsp_stall);

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= sfr_pkg::HeaderReset;
         footer_ff    <= sfr_pkg::FooterReset;
         in_valid_ff  <= 1'b0;
         in_frame_ff  <= 1'b0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         header_ff    <= header_in;
         footer_ff    <= footer_in;
         in_valid_ff  <= in_valid_in;
         in_frame_ff  <= in_frame_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload and result data, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rx_sum_ff  <= rx_sum_in;
      if (payload_we) begin
         payload_ff[payload_idx] <= in_byte_ff;
      end
      if (out_load) begin
         out_payload_ff <= payload_ff;
         out_status_ff  <= out_status_in;
      end
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid          = out_valid_ff;
   assign rsp_command        = out_payload_ff[0];
   assign rsp_board          = out_payload_ff[1];
   assign rsp_channel_number = out_payload_ff[2];
   assign rsp_first_param    = out_payload_ff[3];
   assign rsp_second_param   = out_payload_ff[4];
   assign rsp_status         = out_status_ff;

   // ---------------------------------------------------------------- assertions
   // hunting state always sits at position zero
   a_hunt_pos: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> pos_ff == '0)
      else $error("position nonzero while hunting");

   // inside a frame the position never falls back to zero
   a_frame_pos: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> pos_ff != '0)
      else $error("position zero inside a frame");

   // the input side only stalls behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall))
      else $error("request stalled without output backpressure");

   // a footer byte that moves on always produces a result next cycle
   a_footer_result: assert property (@(posedge clock) disable iff (reset)
      (advance && in_frame_ff && pos_ff == sfr_pkg::FooterPos) |=> out_valid_ff)
      else $error("frame end gave no result");

endmodule
